// File: src/note_driven_wavetable_oscillator_unit_assert.svh
// Assertion macros for the oscillator unit.
`ifndef NOTE_DRIVEN_WAVETABLE_OSCILLATOR_UNIT_ASSERT_SVH
`define NOTE_DRIVEN_WAVETABLE_OSCILLATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define NDWO_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("oscillator assertion failed");
`define NDWO_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("oscillator assertion failed");
`define NDWO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("oscillator assertion failed");
`else
`define NDWO_ASSERT_NEVER(lbl, cond)
`define NDWO_ASSERT_IMPLIES(lbl, ante, cons)
`define NDWO_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/ndwo_pkg.sv
`timescale 1ns / 1ps
package ndwo_pkg;

    localparam int unsigned TABLE_SIZE = 1024;
    localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
    localparam int unsigned PHASE_W    = 32;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned CFG_W      = 36;
    localparam int unsigned KEY_W      = 7;
    localparam int unsigned PID_W      = 16;
    localparam int unsigned GAIN_W     = 17;
    localparam int unsigned SAMPLE_W   = 16;

    localparam logic [CFG_W-1:0]  CFG_RESET  = 36'd5864062015;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;
    localparam logic [PID_W-1:0]  PID_GAIN   = '0;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_NOTE_ON  = 2'd1,
        MODE_NOTE_OFF = 2'd2,
        MODE_SET_GAIN = 2'd3
    } mode_t;

    typedef struct packed {
        logic  accept;
        mode_t mode;
        logic  rd1;
        logic  interp;
        logic  scale;
        logic  emit;
        logic  emit_zero;
        logic  freq;
        logic  mul;
        logic  sum;
    } dp_cmd_t;

    typedef struct packed {
        logic playing;
    } dp_status_t;

endpackage

// File: src/ndwo_ctrl.sv
`timescale 1ns / 1ps
module ndwo_ctrl
    import ndwo_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD1,
        ST_INTERP,
        ST_SCALE,
        ST_EMIT,
        ST_ZERO,
        ST_FREQ,
        ST_MUL,
        ST_SUM
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;
    mode_t  mode;

    assign mode     = mode_t'(s_mode);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.mode      = mode;
        cmd.rd1       = (state_reg == ST_RD1);
        cmd.interp    = (state_reg == ST_INTERP);
        cmd.scale     = (state_reg == ST_SCALE);
        cmd.emit      = (state_reg == ST_EMIT) && out_free;
        cmd.emit_zero = (state_reg == ST_ZERO) && out_free;
        cmd.freq      = (state_reg == ST_FREQ);
        cmd.mul       = (state_reg == ST_MUL);
        cmd.sum       = (state_reg == ST_SUM);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (mode)
                        MODE_TICK:     state_next = status.playing ? ST_RD1 : ST_ZERO;
                        MODE_NOTE_ON:  state_next = ST_FREQ;
                        MODE_NOTE_OFF: state_next = ST_IDLE;
                        MODE_SET_GAIN: state_next = ST_IDLE;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD1:    state_next = ST_INTERP;
            ST_INTERP: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_EMIT;
            ST_EMIT:   state_next = out_free ? ST_IDLE : ST_EMIT;
            ST_ZERO:   state_next = out_free ? ST_IDLE : ST_ZERO;
            ST_FREQ:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_SUM;
            ST_SUM:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit || cmd.emit_zero) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: src/ndwo_dpath.sv
`timescale 1ns / 1ps
module ndwo_dpath
    import ndwo_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic [KEY_W-1:0]           s_key,
    input  logic [PID_W-1:0]           s_param_id,
    input  logic [GAIN_W-1:0]          s_gain_value,
    output logic signed [SAMPLE_W-1:0] m_sample,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 status
);

    localparam int unsigned QTR_SIZE = TABLE_SIZE / 4;
    localparam int unsigned QTR_W    = IDX_W - 2;
    localparam int unsigned MAG_W    = SAMPLE_W - 1;
    localparam int unsigned KEYS     = 1 << KEY_W;
    localparam int unsigned ACC_W    = 34;
    localparam int unsigned PROD_W   = ACC_W + GAIN_W + 1;
    localparam int unsigned Y_W      = PROD_W - 32;
    localparam int unsigned STEP_SH  = 64 - PHASE_W;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] Q30_HALF   = 64'd1 << 29;
    localparam logic [63:0] FULL_SCALE = 64'd32767;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << 31);
    localparam logic signed [Y_W-1:0]    Y_MAX      = Y_W'(32767);
    localparam logic signed [Y_W-1:0]    Y_MIN      = -Y_W'(32768);
    localparam logic signed [SAMPLE_W-1:0] SAT_HI   = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_LO   = 16'sh8000;

    // 440 * 2^(s/12) Hz as Q16.16 for the octave starting at A4
    localparam logic [31:0] OCTAVE [12] = '{
        32'd28835840, 32'd30550508, 32'd32367136, 32'd34291786,
        32'd36330882, 32'd38491228, 32'd40780036, 32'd43204943,
        32'd45774043, 32'd48495909, 32'd51379626, 32'd54434817
    };

    typedef logic [MAG_W-1:0] qsine_tab_t [QTR_SIZE];
    typedef logic [31:0]      freq_tab_t [KEYS];

    // round(32767 * sin(2*pi*j/TABLE_SIZE)) via Q30 Taylor series
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] v;
        x    = (64'(j) * TWO_PI_Q30 + 64'(TABLE_SIZE / 2)) / TABLE_SIZE;
        x2   = (x * x + Q30_HALF) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 6; n++) begin
            term = (term * x2 + Q30_HALF) >> 30;
            unique case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if (n[0]) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        v = (acc * FULL_SCALE + Q30_HALF) >> 30;
        if (v > FULL_SCALE) begin
            v = FULL_SCALE;
        end
        return v[MAG_W-1:0];
    endfunction

    function automatic qsine_tab_t build_qsine();
        qsine_tab_t t;
        for (int i = 0; i < QTR_SIZE; i++) begin
            t[i] = quarter_sine(i);
        end
        return t;
    endfunction

    function automatic logic [31:0] key_freq(input int unsigned key);
        int unsigned d;
        int          o;
        logic [63:0] base;
        d    = key + 3;
        base = 64'(OCTAVE[d % 12]);
        o    = int'(d / 12) - 6;
        if (o >= 0) begin
            return 32'(base << o);
        end
        return 32'((base + (64'd1 << (-o - 1))) >> (-o));
    endfunction

    function automatic freq_tab_t build_freq();
        freq_tab_t t;
        for (int k = 0; k < KEYS; k++) begin
            t[k] = key_freq(k);
        end
        return t;
    endfunction

    localparam qsine_tab_t       QSINE    = build_qsine();
    localparam logic [MAG_W-1:0] QPEAK    = quarter_sine(QTR_SIZE);
    localparam freq_tab_t        FREQ_TAB = build_freq();

    // full-wave lookup from the quarter table
    function automatic logic signed [SAMPLE_W-1:0] sine_at(input logic [IDX_W-1:0] i);
        logic [QTR_W-1:0]           j;
        logic [MAG_W-1:0]           m;
        logic signed [SAMPLE_W-1:0] mag;
        j = i[QTR_W-1:0];
        if (i[QTR_W]) begin
            m = (j == '0) ? QPEAK : QSINE[QTR_W'(-j)];
        end else begin
            m = QSINE[j];
        end
        mag = signed'({1'b0, m});
        return i[QTR_W+1] ? -mag : mag;
    endfunction

    logic [CFG_W-1:0]           cfg_reg;
    logic                       playing_reg;
    logic [KEY_W-1:0]           held_key_reg;
    logic [PHASE_W-1:0]         phase_reg;
    logic [PHASE_W-1:0]         step_reg;
    logic [GAIN_W-1:0]          gain_reg;

    logic signed [SAMPLE_W-1:0] rd_reg;
    logic signed [SAMPLE_W-1:0] s0_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [31:0]                freq_reg;
    logic [63:0]                p0_reg;
    logic [PHASE_W-1:0]         p1_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;

    logic [IDX_W-1:0]           idx;
    logic [IDX_W-1:0]           idx_nxt;
    logic [FRAC_W-1:0]          frac;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [ACC_W-1:0]    slope;
    logic signed [ACC_W-1:0]    acc_base;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic signed [Y_W-1:0]      y;
    logic signed [SAMPLE_W-1:0] sat;
    logic [PHASE_W-1:0]         step_next;

    assign idx     = phase_reg[PHASE_W-1 -: IDX_W];
    assign idx_nxt = idx + IDX_W'(1);
    assign frac    = phase_reg[PHASE_W-IDX_W-1 -: FRAC_W];

    assign diff      = {rd_reg[SAMPLE_W-1], rd_reg} - {s0_reg[SAMPLE_W-1], s0_reg};
    assign slope     = ACC_W'(diff) * ACC_W'($signed({1'b0, frac}));
    assign acc_base  = {{(ACC_W-SAMPLE_W-FRAC_W){s0_reg[SAMPLE_W-1]}}, s0_reg, {FRAC_W{1'b0}}};
    assign acc_next  = acc_base + slope;
    assign prod_next = PROD_W'(acc_reg) * PROD_W'($signed({1'b0, gain_reg}));
    assign prod_rnd  = prod_reg + ROUND_HALF;
    assign y         = prod_rnd[PROD_W-1 -: Y_W];

    always_comb begin
        if (y > Y_MAX) begin
            sat = SAT_HI;
        end else if (y < Y_MIN) begin
            sat = SAT_LO;
        end else begin
            sat = y[SAMPLE_W-1:0];
        end
    end

    // bits [63:32] of freq * cfg, with the upper partial product folded in
    assign step_next = p0_reg[STEP_SH +: PHASE_W] + p1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= CFG_RESET;
            playing_reg  <= 1'b0;
            held_key_reg <= '0;
            phase_reg    <= '0;
            step_reg     <= '0;
            gain_reg     <= GAIN_RESET;
        end else begin
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                unique case (cmd.mode)
                    MODE_NOTE_ON: begin
                        playing_reg  <= 1'b1;
                        held_key_reg <= s_key;
                        phase_reg    <= '0;
                    end
                    MODE_NOTE_OFF: begin
                        if (playing_reg && held_key_reg == s_key) begin
                            playing_reg <= 1'b0;
                        end
                    end
                    MODE_SET_GAIN: begin
                        if (s_param_id == PID_GAIN) begin
                            gain_reg <= s_gain_value;
                        end
                    end
                    MODE_TICK: begin
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.emit) begin
                phase_reg <= phase_reg + step_reg;
            end
            if (cmd.sum) begin
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        // first sine read goes out with the transfer itself
        if (cmd.accept) begin
            rd_reg <= sine_at(idx);
        end
        if (cmd.rd1) begin
            s0_reg <= rd_reg;
            rd_reg <= sine_at(idx_nxt);
        end
        if (cmd.interp) begin
            acc_reg <= acc_next;
        end
        if (cmd.scale) begin
            prod_reg <= prod_next;
        end
        if (cmd.freq) begin
            freq_reg <= FREQ_TAB[held_key_reg];
        end
        if (cmd.mul) begin
            p0_reg <= 64'(freq_reg) * 64'(cfg_reg[31:0]);
            p1_reg <= PHASE_W'(freq_reg * cfg_reg[CFG_W-1:32]);
        end
        if (cmd.emit) begin
            m_sample_reg <= sat;
        end else if (cmd.emit_zero) begin
            m_sample_reg <= '0;
        end
    end

    assign m_sample       = m_sample_reg;
    assign status.playing = playing_reg;

endmodule

// File: src/note_driven_wavetable_oscillator_unit.sv
`timescale 1ns / 1ps
// Monophonic note-driven sine oscillator. Each input transfer is one event:
// tick, note on, note off or gain set; only a tick returns a sample. A tick
// while a note plays goes from its transfer to the result register through
// two reads of the sine table, the interpolation multiply, the gain multiply
// and rounding/saturation, run in turn by one sequencer on one datapath. A
// tick with no note returns zero. A note on runs the frequency table, the
// split 32x36 step multiply and the partial product add; note off and gain
// set act at the transfer. One item is worked at a time; the result sits in an
// output register, so the next event can enter while it waits for m_ready,
// and a later tick holds in its last step only while that register is full.
// phase_step_per_hz is written through cfg_we/cfg_wdata and takes effect at
// the next note on.
`include "note_driven_wavetable_oscillator_unit_assert.svh"
module note_driven_wavetable_oscillator_unit
    import ndwo_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_mode,
    input  logic [KEY_W-1:0]           s_key,
    input  logic [PID_W-1:0]           s_param_id,
    input  logic [GAIN_W-1:0]          s_gain_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    ndwo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    ndwo_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_key        (s_key),
        .s_param_id   (s_param_id),
        .s_gain_value (s_gain_value),
        .m_sample     (m_sample),
        .cmd          (dp_cmd),
        .status       (dp_status)
    );

    `NDWO_ASSERT_NEVER(a_single_step, !$onehot0({dp_cmd.rd1, dp_cmd.interp, dp_cmd.scale, dp_cmd.emit, dp_cmd.emit_zero, dp_cmd.freq, dp_cmd.mul, dp_cmd.sum}))
    `NDWO_ASSERT_IMPLIES(a_no_overwrite, dp_cmd.emit || dp_cmd.emit_zero, !m_valid || m_ready)
    `NDWO_ASSERT_NEXT(a_tick_busy, s_valid && s_ready && s_mode == MODE_TICK, !s_ready)
    `NDWO_ASSERT_NEXT(a_note_on_step, s_valid && s_ready && s_mode == MODE_NOTE_ON, dp_cmd.freq)

endmodule
